FILE: hdl/fir_lp_pkg.sv
// Shared types, constants and the weight table of the low-pass FIR filter.
// Used by the controller, the datapath and the top level; no dependencies.
package fir_lp_pkg;

    localparam int TAPS      = 28;
    localparam int FRAC_BITS = 8;
    localparam int SAMPLE_W  = 16;
    localparam int WEIGHT_W  = 8;
    localparam int OUT_W     = 17;
    localparam int PROD_W    = SAMPLE_W + WEIGHT_W;
    localparam int TAP_IDX_W = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int BASE_TAPS = 28;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [WEIGHT_W-1:0] weight_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [OUT_W-1:0]    acc_t;
    typedef logic [TAP_IDX_W-1:0]       tap_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_LAST,
        ST_DONE
    } fir_lp_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     shift_in;
        logic     rotate;
        logic     mult_en;
        logic     acc_add;
        logic     load_out;
        tap_idx_t tap_idx;
    } fir_lp_cmd_t;

    localparam weight_t BASE_WEIGHT [BASE_TAPS] = '{
        8'sd0, 8'sd0, 8'sd0, 8'sd1, 8'sd3, 8'sd4, 8'sd1, -8'sd5, -8'sd11, -8'sd10,
        8'sd2, 8'sd25, 8'sd51, 8'sd68,
        8'sd68, 8'sd51, 8'sd25, 8'sd2, -8'sd10, -8'sd11, -8'sd5, 8'sd1, 8'sd4,
        8'sd3, 8'sd1, 8'sd0, 8'sd0, 8'sd0
    };

    // Taps past the symmetric base set carry weight zero.
    function automatic weight_t tap_weight(tap_idx_t idx);
        weight_t w;
        w = '0;
        for (int i = 0; i < BASE_TAPS; i++) begin
            if (i < TAPS && int'(idx) == i) begin
                w = BASE_WEIGHT[i];
            end
        end
        return w;
    endfunction

endpackage

FILE: hdl/fir_lowpass_q8.sv
// Top level of the 28-tap Q8 low-pass FIR filter.
// Instantiates fir_lp_ctrl and fir_lp_dp; depends on fir_lp_pkg.
//
//   channel | ports                          | direction
//   --------+--------------------------------+----------
//   sample  | s_valid, s_ready, s_sample     | in
//   result  | m_valid, m_ready, m_filtered   | out
//
// A result takes one multiply-accumulate per tap through a single 16x8 multiplier in ST_MAC;
// ST_LAST then adds the last product and ST_DONE loads the output register. The next sample
// is taken back in ST_IDLE, after the load; while the previous result still sits in the output
// register waiting for its transfer, ST_DONE holds the new sum and no sample is taken.
// Reset is synchronous and active low and clears the delay line to zero.
// A stalled output holds the finished sum in the controller's done state.
module fir_lowpass_q8 (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  fir_lp_pkg::sample_t s_sample,
    output logic                m_valid,
    input  logic                m_ready,
    output fir_lp_pkg::acc_t    m_filtered
);
    import fir_lp_pkg::*;

    fir_lp_cmd_t cmd;

    fir_lp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    fir_lp_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .s_sample   (s_sample),
        .m_filtered (m_filtered)
    );

endmodule

FILE: hdl/fir_lp_ctrl.sv
// Controller of the low-pass FIR filter: sequences the tap loop and owns
// the input ready and output valid. Depends on fir_lp_pkg.
module fir_lp_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output fir_lp_pkg::fir_lp_cmd_t cmd
);
    import fir_lp_pkg::*;

    fir_lp_state_t state_reg, state_next;
    tap_idx_t      cnt_reg, cnt_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_free;

    assign out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_MAC;
            end
            ST_MAC: begin
                if (cnt_reg == tap_idx_t'(TAPS - 1)) state_next = ST_LAST;
            end
            ST_LAST: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready        = 1'b0;
        cmd            = '0;
        cmd.tap_idx    = cnt_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready      = 1'b1;
                cmd.shift_in = s_valid;
                cnt_next     = '0;
            end
            ST_MAC: begin
                cmd.mult_en = 1'b1;
                cmd.rotate  = 1'b1;
                // The product of the previous tap is registered and added in the next cycle.
                cmd.acc_add = (cnt_reg != '0);
                cnt_next    = cnt_reg + tap_idx_t'(1);
            end
            ST_LAST: begin
                cmd.acc_add = 1'b1;
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default: begin
                cnt_next = '0;
            end
        endcase
    end

    assign m_valid = out_valid_reg;

endmodule

FILE: hdl/fir_lp_dp.sv
// Datapath of the low-pass FIR filter: delay line, one multiplier,
// accumulator and output register. Depends on fir_lp_pkg.
module fir_lp_dp (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  fir_lp_pkg::fir_lp_cmd_t cmd,
    input  fir_lp_pkg::sample_t     s_sample,
    output fir_lp_pkg::acc_t        m_filtered
);
    import fir_lp_pkg::*;

    sample_t delay_reg [TAPS];
    sample_t delay_next [TAPS];
    prod_t   prod_reg, prod_next;
    acc_t    acc_reg, acc_next;
    acc_t    out_reg, out_next;
    logic signed [PROD_W-FRAC_BITS-1:0] tap_term;

    // The line rotates once per tap so that position 0 always holds the
    // sample of the current tap; after a full pass it is back in order.
    always_comb begin
        for (int i = 0; i < TAPS; i++) begin
            delay_next[i] = delay_reg[i];
        end
        if (cmd.shift_in) begin
            delay_next[0] = s_sample;
            for (int i = 1; i < TAPS; i++) begin
                delay_next[i] = delay_reg[i-1];
            end
        end else if (cmd.rotate) begin
            for (int i = 0; i < TAPS - 1; i++) begin
                delay_next[i] = delay_reg[i+1];
            end
            delay_next[TAPS-1] = delay_reg[0];
        end
    end

    // Arithmetic shift floors each tap product on its own.
    assign tap_term = prod_reg[PROD_W-1:FRAC_BITS];

    always_comb begin
        prod_next = prod_reg;
        acc_next  = acc_reg;
        out_next  = out_reg;
        if (cmd.mult_en) begin
            prod_next = prod_t'(delay_reg[0] * tap_weight(cmd.tap_idx));
        end
        if (cmd.shift_in) begin
            acc_next = '0;
        end else if (cmd.acc_add) begin
            acc_next = acc_reg + acc_t'(tap_term);
        end
        if (cmd.load_out) begin
            out_next = acc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TAPS; i++) begin
                delay_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < TAPS; i++) begin
                delay_reg[i] <= delay_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        out_reg  <= out_next;
    end

    assign m_filtered = out_reg;

endmodule

FILE: sim/fir_lowpass_q8_test.sv
// Self-checking testbench for the 28-tap Q8 low-pass FIR filter top level.
// Drives samples with random gaps, predicts each filtered value and checks it on the fly.
// Depends on fir_lp_pkg and fir_lowpass_q8.
module fir_lowpass_q8_test;

    timeunit 1ns;
    timeprecision 1ps;

    import fir_lp_pkg::sample_t;
    import fir_lp_pkg::acc_t;

    localparam int NTAPS        = fir_lp_pkg::TAPS;
    localparam int SHIFT        = fir_lp_pkg::FRAC_BITS;
    localparam int RANDOM_ITEMS = 1700;
    localparam int IDLE_PCT     = 12;
    localparam int CALM_FIRST   = 600;
    localparam int CALM_LAST    = 900;
    localparam int DRAIN_CYCLES = 40;
    localparam int QUIET_LIMIT  = 4000;
    localparam int MAX_REPORTS  = 10;

    // Q8 low-pass weights, newest sample first.
    localparam int COEF [NTAPS] = '{
        0, 0, 0, 1, 3, 4, 1, -5, -11, -10, 2, 25, 51, 68,
        68, 51, 25, 2, -10, -11, -5, 1, 4, 3, 1, 0, 0, 0
    };

    typedef struct packed {
        logic signed [15:0] smp;
        logic               known;
        logic signed [16:0] want;
    } stim_row_t;

    localparam int DIRECTED_N = 24;
    localparam stim_row_t DIRECTED [DIRECTED_N] = '{
        '{16'sh7FFF, 1'b1, 17'sd0},
        '{16'sh8000, 1'b1, 17'sd0},
        '{16'sh0000, 1'b1, 17'sd0},
        '{16'sh0000, 1'b1, 17'sd127},
        // A run of -1 samples: every small negative product floors to -1.
        '{16'shFFFF, 1'b0, 17'sd0},
        '{16'shFFFF, 1'b0, 17'sd0},
        '{16'shFFFF, 1'b0, 17'sd0},
        '{16'shFFFF, 1'b0, 17'sd0},
        '{16'shFFFF, 1'b0, 17'sd0},
        '{16'shFFFF, 1'b0, 17'sd0},
        '{16'sh0001, 1'b0, 17'sd0},
        '{16'sh0001, 1'b0, 17'sd0},
        '{16'sh8000, 1'b0, 17'sd0},
        '{16'sh8000, 1'b0, 17'sd0},
        '{16'sh8000, 1'b0, 17'sd0},
        '{16'sh7FFF, 1'b0, 17'sd0},
        '{16'sh7FFF, 1'b0, 17'sd0},
        '{16'sh7FFF, 1'b0, 17'sd0},
        '{16'sh5555, 1'b0, 17'sd0},
        '{16'shAAAA, 1'b0, 17'sd0},
        '{16'sh00FF, 1'b0, 17'sd0},
        '{16'shFF00, 1'b0, 17'sd0},
        '{16'sh0080, 1'b0, 17'sd0},
        '{16'shFF80, 1'b0, 17'sd0}
    };

    logic    aclk     = 1'b0;
    logic    aresetn  = 1'b0;
    logic    s_valid  = 1'b0;
    logic    s_ready;
    sample_t s_sample = '0;
    logic    m_valid;
    logic    m_ready  = 1'b0;
    acc_t    m_filtered;

    sample_t history [NTAPS];
    acc_t    filtered_q [$];
    int      samples_sent = 0;
    int      mismatches   = 0;
    int      quiet_cycles = 0;
    bit      calm         = 1'b0;

    fir_lowpass_q8 dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample   (s_sample),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_filtered (m_filtered)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Shifts a sample into the delay line and returns the filtered value.
    // Each tap product is floored by the arithmetic shift before it is summed.
    function automatic acc_t filter_step(sample_t smp);
        int sum;
        int prod;
        sum = 0;
        for (int i = NTAPS - 1; i > 0; i--) begin
            history[i] = history[i-1];
        end
        history[0] = smp;
        for (int i = 0; i < NTAPS; i++) begin
            prod = int'(history[i]) * COEF[i];
            sum += prod >>> SHIFT;
        end
        return acc_t'(sum);
    endfunction

    task automatic send_sample(input sample_t smp, input bit known, input acc_t want);
        acc_t model;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= smp;
        do @(posedge aclk); while (!(s_valid && s_ready));
        model = filter_step(smp);
        filtered_q.push_back(known ? want : model);
        samples_sent++;
        calm = (samples_sent >= CALM_FIRST && samples_sent < CALM_LAST);
        @(negedge aclk);
    endtask

    task automatic report_mismatch(input string what, input acc_t want, input acc_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
        end
    endtask

    always @(negedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (filtered_q.size() == 0) begin
                report_mismatch("result with no sample pending", '0, m_filtered);
            end else if (m_filtered !== filtered_q[0]) begin
                report_mismatch("filtered value", filtered_q[0], m_filtered);
                void'(filtered_q.pop_front());
            end else begin
                void'(filtered_q.pop_front());
            end
        end
    end

    // Ends the run if no transfer happens on either channel for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        int      pick;
        bit      flip;
        sample_t smp;
        foreach (history[i]) begin
            history[i] = '0;
        end
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < DIRECTED_N; i++) begin
            send_sample(DIRECTED[i].smp, DIRECTED[i].known, DIRECTED[i].want);
        end

        while (samples_sent < DIRECTED_N + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick <= 3) begin
                send_sample(sample_t'($urandom), 1'b0, '0);
            end else if (pick == 4) begin
                send_sample($urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000, 1'b0, '0);
            end else if (pick <= 6) begin
                smp = sample_t'(int'($urandom_range(0, 600)) - 300);
                send_sample(smp, 1'b0, '0);
            end else if (pick == 7) begin
                // Full-scale samples lined up with the weight signs drive the sum
                // to its largest magnitude, positive or negative.
                flip = bit'($urandom_range(0, 1));
                for (int j = 0; j < NTAPS; j++) begin
                    smp = ((COEF[NTAPS-1-j] >= 0) ^ flip) ? 16'sh7FFF : 16'sh8000;
                    send_sample(smp, 1'b0, '0);
                end
            end else if (pick == 8) begin
                for (int j = 0; j < NTAPS; j++) begin
                    send_sample($urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000, 1'b0, '0);
                end
            end else begin
                smp = sample_t'(-int'($urandom_range(1, 4)));
                repeat ($urandom_range(4, 30)) send_sample(smp, 1'b0, '0);
            end
        end
        s_valid <= 1'b0;

        wait (filtered_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
